// ===== src/motor_feedback_multiturn_tracker_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the motor feedback multi-turn tracker
// Clocked on clk and disabled during rst in the module that uses them.
// ----------------------------------------------------------------------------
`ifndef MOTOR_FEEDBACK_MULTITURN_TRACKER_CORE_ASSERT_SVH
`define MOTOR_FEEDBACK_MULTITURN_TRACKER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MTT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mtt_pkg.sv =====
// ----------------------------------------------------------------------------
// mtt_pkg
// Widths, constants and shared types of the multi-turn tracker.
// ----------------------------------------------------------------------------
package mtt_pkg;

  localparam int TURN_COUNT_BITS = 32;
  localparam int WRAP_THRESHOLD  = 4200;

  // pi in Q16, degrees Q16 per encoder count (360*65536/8192), 24*80
  localparam int PI_Q16           = 205887;
  localparam int DEG_PER_COUNT    = 2880;
  localparam int NT_SCALE         = 1920;
  localparam int CUR_SCALE        = 80;
  localparam int SPEED_DIV        = 30;
  localparam int DQ_OFFSET        = 131072;
  localparam int COUNT_SHIFT      = 13;

  localparam int RR_W   = 16;
  localparam int PB_W   = 14;
  localparam int POS_W  = 16;
  localparam int SPD_W  = 16;
  localparam int CUR_W  = 23;
  localparam int TQ_W   = 32;
  localparam int TEMP_W = 8;
  localparam int ANG_W  = 48;
  localparam int CFG_W  = 16;
  localparam int IDX_W  = 2;

  localparam int SPD_MAG_W = 33;
  localparam int DEN_W     = 21;
  localparam int DQ_Q_W    = 36;
  localparam int DQ_W      = 38;
  localparam int DSR_W     = 37;
  localparam int NT_W      = 27;
  localparam int NT_MAG_W  = 26;

  localparam int SUM_W     = TURN_COUNT_BITS + 14;
  localparam int MUL_W     = SUM_W + 12;
  localparam int MAG_W     = MUL_W - 1;

  localparam int DQ_DVD_W  = SPD_MAG_W + 8;
  localparam int TQ_DVD_W  = NT_MAG_W + 16;
  localparam int ANG_DVD_W = MAG_W + 8;
  localparam int DIV_W0    = (DQ_DVD_W > TQ_DVD_W) ? DQ_DVD_W : TQ_DVD_W;
  localparam int DIV_W     = (ANG_DVD_W > DIV_W0) ? ANG_DVD_W : DIV_W0;
  localparam int CNT_W     = $clog2(DIV_W + 1);

  localparam logic [IDX_W-1:0] REG_REDUCTION_RATIO   = 2'd0;
  localparam logic [IDX_W-1:0] REG_ANGLE_TRACKING_ON = 2'd1;
  localparam logic [IDX_W-1:0] REG_POSITION_BIAS     = 2'd2;

  localparam logic OP_FEEDBACK = 1'b0;
  localparam logic OP_SET_BIAS = 1'b1;

  localparam logic [RR_W-1:0] RR_RESET = 16'd256;
  localparam logic [PB_W-1:0] PB_UNSET = '1;

  typedef struct packed {
    logic [RR_W-1:0]        reduction_ratio;
    logic                   angle_tracking_on;
    logic signed [PB_W-1:0] position_bias;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
    logic [CNT_W-1:0] count;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic                     valid;
    logic signed [POS_W-1:0]  rotor_position;
    logic signed [SPD_W-1:0]  rotor_speed;
    logic signed [CUR_W-1:0]  current_amps;
    logic signed [TQ_W-1:0]   torque_estimate;
    logic [TEMP_W-1:0]        temperature;
    logic signed [ANG_W-1:0]  output_angle;
    logic                     saturated;
  } res_t;

endpackage

// ===== src/mtt_div.sv =====
// ----------------------------------------------------------------------------
// mtt_div
// Shared restoring divider, one quotient bit per cycle. The dividend comes
// in left aligned; after count steps the quotient sits in the low bits.
// ----------------------------------------------------------------------------
`include "motor_feedback_multiturn_tracker_core_assert.svh"

module mtt_div (
  input  logic              clk,
  input  logic              rst,
  input  mtt_pkg::div_req_t req,
  output mtt_pkg::div_rsp_t rsp
);

  logic                          busy;
  logic                          done;
  logic [mtt_pkg::CNT_W-1:0]     cnt;
  logic [mtt_pkg::DIV_W-1:0]     qr;
  logic [mtt_pkg::DSR_W-1:0]     rem;
  logic [mtt_pkg::DSR_W-1:0]     dsr;
  logic [mtt_pkg::DSR_W:0]       shifted;
  logic [mtt_pkg::DSR_W+1:0]     diff;
  logic                          fits;

  assign shifted = {rem, qr[mtt_pkg::DIV_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr};
  assign fits    = !diff[mtt_pkg::DSR_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.count;
        qr   <= req.dividend;
        rem  <= '0;
        dsr  <= req.divisor;
      end else if (busy) begin
        qr  <= {qr[mtt_pkg::DIV_W-2:0], fits};
        rem <= fits ? diff[mtt_pkg::DSR_W-1:0] : shifted[mtt_pkg::DSR_W-1:0];
        cnt <= cnt - 1'b1;
        if (cnt == mtt_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = qr;

  `MTT_ASSERT_NOW(a_start_idle, req.start, !busy, "divider started while busy")
  `MTT_ASSERT_NEXT(a_last_step_done, busy && cnt == mtt_pkg::CNT_W'(1), done && !busy, "divider missed its last step")
  `MTT_ASSERT_NOW(a_done_idle, done, !busy, "divider done while still busy")

endmodule

// ===== src/mtt_ctrl.sv =====
// ----------------------------------------------------------------------------
// mtt_ctrl
// Sequencer and datapath: decodes a frame, runs the speed term, torque and
// angle divisions on the shared divider and keeps the multi-turn state.
// ----------------------------------------------------------------------------
`include "motor_feedback_multiturn_tracker_core_assert.svh"

module mtt_ctrl (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   operation,
  input  logic signed [mtt_pkg::POS_W-1:0]       position_word,
  input  logic signed [mtt_pkg::SPD_W-1:0]       speed_word,
  input  logic signed [mtt_pkg::SPD_W-1:0]       current_word,
  input  logic [mtt_pkg::TEMP_W-1:0]             temperature_raw,
  input  logic signed [mtt_pkg::ANG_W-1:0]       bias_value,
  input  mtt_pkg::cfg_t                          cfg,
  input  logic                                   out_free,
  output mtt_pkg::res_t                          res,
  output mtt_pkg::div_req_t                      div_req,
  input  mtt_pkg::div_rsp_t                      div_rsp
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_PREP    = 4'd1;
  localparam logic [3:0] S_DQ_GO   = 4'd2;
  localparam logic [3:0] S_DQ_WAIT = 4'd3;
  localparam logic [3:0] S_TQ_GO   = 4'd4;
  localparam logic [3:0] S_TQ_WAIT = 4'd5;
  localparam logic [3:0] S_AN_GO   = 4'd6;
  localparam logic [3:0] S_AN_WAIT = 4'd7;
  localparam logic [3:0] S_BIAS    = 4'd8;
  localparam logic [3:0] S_OUT     = 4'd9;

  localparam int DIFF_W = mtt_pkg::ANG_W + 1;
  localparam int D_W    = mtt_pkg::POS_W + 1;

  localparam logic [mtt_pkg::DIV_W-1:0] TQ_LIM =
    mtt_pkg::DIV_W'(1) << (mtt_pkg::TQ_W - 1);
  localparam logic [mtt_pkg::DIV_W-1:0] ANG_LIM =
    mtt_pkg::DIV_W'(1) << (mtt_pkg::ANG_W - 1);
  localparam logic signed [mtt_pkg::TQ_W-1:0] TQ_MAX =
    {1'b0, {(mtt_pkg::TQ_W-1){1'b1}}};
  localparam logic signed [mtt_pkg::TQ_W-1:0] TQ_MIN =
    {1'b1, {(mtt_pkg::TQ_W-1){1'b0}}};
  localparam logic signed [mtt_pkg::ANG_W-1:0] ANG_MAX =
    {1'b0, {(mtt_pkg::ANG_W-1){1'b1}}};
  localparam logic signed [mtt_pkg::ANG_W-1:0] ANG_MIN =
    {1'b1, {(mtt_pkg::ANG_W-1){1'b0}}};
  localparam logic signed [D_W-1:0] WRAP = D_W'(mtt_pkg::WRAP_THRESHOLD);

  logic [3:0]                                state;

  logic signed [mtt_pkg::POS_W-1:0]          pos_r;
  logic signed [mtt_pkg::SPD_W-1:0]          spd_r;
  logic signed [mtt_pkg::SPD_W-1:0]          cw_r;
  logic [mtt_pkg::TEMP_W-1:0]                temp_r;
  logic [mtt_pkg::RR_W-1:0]                  rr_eff;
  logic signed [mtt_pkg::CUR_W-1:0]          cur_r;
  logic signed [mtt_pkg::NT_W-1:0]           nt_r;
  logic                                      spd_neg;
  logic [mtt_pkg::SPD_MAG_W-1:0]             spd_mag;
  logic [mtt_pkg::DEN_W-1:0]                 den30;
  logic signed [mtt_pkg::SUM_W-1:0]          s_sum;
  logic signed [mtt_pkg::MUL_W-1:0]          s_mul;
  logic                                      ang_neg;
  logic [mtt_pkg::MAG_W-1:0]                 ang_mag;
  logic signed [mtt_pkg::DQ_W-1:0]           dq_r;
  logic signed [mtt_pkg::TQ_W-1:0]           torque_r;
  logic                                      sat_r;
  logic signed [mtt_pkg::ANG_W-1:0]          ang_r;

  logic [mtt_pkg::TURN_COUNT_BITS-1:0]       turn_count;
  logic signed [mtt_pkg::POS_W-1:0]          prev_pos;
  logic                                      prev_valid;
  logic signed [mtt_pkg::ANG_W-1:0]          angle_offset;
  logic                                      offset_init;
  logic signed [mtt_pkg::ANG_W-1:0]          held_angle;

  logic [mtt_pkg::SPD_W:0]                   spd_abs;
  logic signed [D_W-1:0]                     pos_delta;
  logic signed [mtt_pkg::DQ_W-1:0]           dq_q;
  logic [mtt_pkg::DSR_W-1:0]                 dq_abs;
  logic                                      nt_pos;
  logic                                      tq_needed;
  logic signed [mtt_pkg::ANG_W-1:0]          off_eff;
  logic signed [DIFF_W-1:0]                  ang_diff;
  logic                                      ang_ovf;

  assign in_ready = (state == S_IDLE);

  assign spd_abs   = spd_r[mtt_pkg::SPD_W-1] ? (mtt_pkg::SPD_W+1)'(-(D_W'(spd_r)))
                                             : (mtt_pkg::SPD_W+1)'(spd_r);
  assign pos_delta = D_W'(pos_r) - D_W'(prev_pos);
  assign dq_q      = signed'(mtt_pkg::DQ_W'(div_rsp.quotient[mtt_pkg::DQ_Q_W-1:0]));
  assign dq_abs    = dq_r[mtt_pkg::DQ_W-1] ? mtt_pkg::DSR_W'(-dq_r)
                                           : mtt_pkg::DSR_W'(dq_r);
  assign nt_pos    = !nt_r[mtt_pkg::NT_W-1] && (nt_r != '0);
  assign tq_needed = nt_pos && (dq_r != '0);

  // The first angle seen sets the bias unless a rotor position bias is configured.
  assign off_eff  = offset_init ? angle_offset :
                    (cfg.position_bias != mtt_pkg::PB_UNSET) ?
                      mtt_pkg::ANG_W'(cfg.position_bias) *
                      mtt_pkg::ANG_W'(mtt_pkg::DEG_PER_COUNT) :
                      ang_r;
  assign ang_diff = DIFF_W'(ang_r) - DIFF_W'(off_eff);
  assign ang_ovf  = ang_diff[DIFF_W-1] != ang_diff[DIFF_W-2];

  always_comb begin
    div_req = '0;
    unique case (state)
      S_DQ_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = mtt_pkg::DIV_W'(spd_mag) << (mtt_pkg::DIV_W - mtt_pkg::SPD_MAG_W);
        div_req.divisor  = mtt_pkg::DSR_W'(den30);
        div_req.count    = mtt_pkg::CNT_W'(mtt_pkg::DQ_DVD_W);
      end
      S_TQ_GO: begin
        div_req.start    = tq_needed;
        div_req.dividend = mtt_pkg::DIV_W'(nt_r[mtt_pkg::NT_MAG_W-1:0])
                           << (mtt_pkg::DIV_W - mtt_pkg::NT_MAG_W);
        div_req.divisor  = dq_abs;
        div_req.count    = mtt_pkg::CNT_W'(mtt_pkg::TQ_DVD_W);
      end
      S_AN_GO: begin
        div_req.start    = cfg.angle_tracking_on;
        div_req.dividend = mtt_pkg::DIV_W'(ang_mag) << (mtt_pkg::DIV_W - mtt_pkg::MAG_W);
        div_req.divisor  = mtt_pkg::DSR_W'(rr_eff);
        div_req.count    = mtt_pkg::CNT_W'(mtt_pkg::ANG_DVD_W);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      turn_count   <= '0;
      prev_pos     <= '0;
      prev_valid   <= 1'b0;
      angle_offset <= '0;
      offset_init  <= 1'b0;
      held_angle   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (operation == mtt_pkg::OP_SET_BIAS) begin
              angle_offset <= bias_value;
              offset_init  <= 1'b1;
              prev_valid   <= 1'b0;
            end else begin
              pos_r  <= position_word;
              spd_r  <= speed_word;
              cw_r   <= current_word;
              temp_r <= temperature_raw;
              rr_eff <= (cfg.reduction_ratio == '0) ? mtt_pkg::RR_W'(1)
                                                    : cfg.reduction_ratio;
              state  <= S_PREP;
            end
          end
        end
        S_PREP: begin
          cur_r   <= mtt_pkg::CUR_W'(cw_r) * mtt_pkg::CUR_W'(mtt_pkg::CUR_SCALE);
          nt_r    <= mtt_pkg::NT_W'(cw_r) * mtt_pkg::NT_W'(mtt_pkg::NT_SCALE);
          spd_neg <= spd_r[mtt_pkg::SPD_W-1];
          spd_mag <= mtt_pkg::SPD_MAG_W'((mtt_pkg::SPD_MAG_W+2)'(spd_abs) *
                                         (mtt_pkg::SPD_MAG_W+2)'(mtt_pkg::PI_Q16));
          den30   <= mtt_pkg::DEN_W'(rr_eff) * mtt_pkg::DEN_W'(mtt_pkg::SPEED_DIV);
          // Count a turn on a large jump of the encoder position.
          if (cfg.angle_tracking_on && prev_valid) begin
            if (pos_delta < -WRAP) begin
              turn_count <= turn_count + 1'b1;
            end else if (pos_delta > WRAP) begin
              turn_count <= turn_count - 1'b1;
            end
          end
          state <= S_DQ_GO;
        end
        S_DQ_GO: begin
          s_sum <= mtt_pkg::SUM_W'(pos_r) +
                   (mtt_pkg::SUM_W'(signed'(turn_count)) << mtt_pkg::COUNT_SHIFT);
          state <= S_DQ_WAIT;
        end
        S_DQ_WAIT: begin
          s_mul <= mtt_pkg::MUL_W'(s_sum) * mtt_pkg::MUL_W'(mtt_pkg::DEG_PER_COUNT);
          if (div_rsp.done) begin
            dq_r  <= (spd_neg ? -dq_q : dq_q) + mtt_pkg::DQ_W'(mtt_pkg::DQ_OFFSET);
            state <= S_TQ_GO;
          end
        end
        S_TQ_GO: begin
          ang_neg <= s_mul[mtt_pkg::MUL_W-1];
          ang_mag <= s_mul[mtt_pkg::MUL_W-1] ? mtt_pkg::MAG_W'(-s_mul)
                                             : mtt_pkg::MAG_W'(s_mul);
          if (tq_needed) begin
            state <= S_TQ_WAIT;
          end else begin
            // Zero denominator saturates; no positive drive gives zero torque.
            torque_r <= nt_pos ? TQ_MAX : '0;
            sat_r    <= nt_pos;
            state    <= S_AN_GO;
          end
        end
        S_TQ_WAIT: begin
          if (div_rsp.done) begin
            if (dq_r[mtt_pkg::DQ_W-1]) begin
              sat_r    <= div_rsp.quotient > TQ_LIM;
              torque_r <= (div_rsp.quotient > TQ_LIM) ? TQ_MIN
                          : -(mtt_pkg::TQ_W'(div_rsp.quotient));
            end else begin
              sat_r    <= div_rsp.quotient >= TQ_LIM;
              torque_r <= (div_rsp.quotient >= TQ_LIM) ? TQ_MAX
                          : mtt_pkg::TQ_W'(div_rsp.quotient);
            end
            state <= S_AN_GO;
          end
        end
        S_AN_GO: begin
          state <= cfg.angle_tracking_on ? S_AN_WAIT : S_OUT;
        end
        S_AN_WAIT: begin
          if (div_rsp.done) begin
            if (ang_neg) begin
              if (div_rsp.quotient > ANG_LIM) begin
                ang_r <= ANG_MIN;
                sat_r <= 1'b1;
              end else begin
                ang_r <= -(mtt_pkg::ANG_W'(div_rsp.quotient));
              end
            end else begin
              if (div_rsp.quotient >= ANG_LIM) begin
                ang_r <= ANG_MAX;
                sat_r <= 1'b1;
              end else begin
                ang_r <= mtt_pkg::ANG_W'(div_rsp.quotient);
              end
            end
            state <= S_BIAS;
          end
        end
        S_BIAS: begin
          angle_offset <= off_eff;
          offset_init  <= 1'b1;
          held_angle   <= ang_ovf ? (ang_diff[DIFF_W-1] ? ANG_MIN : ANG_MAX)
                                  : ang_diff[mtt_pkg::ANG_W-1:0];
          if (ang_ovf) begin
            sat_r <= 1'b1;
          end
          prev_pos   <= pos_r;
          prev_valid <= 1'b1;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    res.valid           = (state == S_OUT) && out_free;
    res.rotor_position  = pos_r;
    res.rotor_speed     = spd_r;
    res.current_amps    = cur_r;
    res.torque_estimate = torque_r;
    res.temperature     = temp_r;
    res.output_angle    = held_angle;
    res.saturated       = sat_r;
  end

  `MTT_ASSERT_NOW(a_res_slot_free, res.valid, out_free, "result issued into a full output register")
  `MTT_ASSERT_NEXT(a_turns_in_prep, state != S_PREP, $stable(turn_count), "turn count moved outside its update step")
  `MTT_ASSERT_NOW(a_div_done_wait, div_rsp.done, state == S_DQ_WAIT || state == S_TQ_WAIT || state == S_AN_WAIT, "divider result arrived with no step waiting")

endmodule

// ===== src/motor_feedback_multiturn_tracker_core.sv =====
// ----------------------------------------------------------------------------
// motor_feedback_multiturn_tracker_core
// Motor feedback decode with torque estimate and multi-turn shaft angle.
// ----------------------------------------------------------------------------
//
//  channel   handshake                  payload
//  -------   -------------------------  ---------------------------------------
//  input     in_valid / in_ready        operation, position_word, speed_word,
//                                       current_word, temperature_raw, bias_value
//  output    out_valid / out_ready      rotor_position, rotor_speed, current_amps,
//                                       torque_estimate, temperature,
//                                       output_angle, saturated
//  config    cfg_we, cfg_index          cfg_data (write only, no wait)
//
//  A feedback frame runs on the bit-serial shared divider: the speed term,
//  then the torque division unless the torque needs none, then the angle
//  division with tracking on. The next frame is accepted only once the
//  current one has left the sequencer. A set-bias item is taken in the idle
//  state and uses no divider step.
//  Reset restores the register defaults and clears the turn and bias state.
//  A result waits in the output register; the next frame is taken meanwhile
//  and holds in its last step while that register is still full.
// ----------------------------------------------------------------------------
module motor_feedback_multiturn_tracker_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                operation,
  input  logic signed [mtt_pkg::POS_W-1:0]    position_word,
  input  logic signed [mtt_pkg::SPD_W-1:0]    speed_word,
  input  logic signed [mtt_pkg::SPD_W-1:0]    current_word,
  input  logic [mtt_pkg::TEMP_W-1:0]          temperature_raw,
  input  logic signed [mtt_pkg::ANG_W-1:0]    bias_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mtt_pkg::POS_W-1:0]    rotor_position,
  output logic signed [mtt_pkg::SPD_W-1:0]    rotor_speed,
  output logic signed [mtt_pkg::CUR_W-1:0]    current_amps,
  output logic signed [mtt_pkg::TQ_W-1:0]     torque_estimate,
  output logic [mtt_pkg::TEMP_W-1:0]          temperature,
  output logic signed [mtt_pkg::ANG_W-1:0]    output_angle,
  output logic                                saturated,
  input  logic                                cfg_we,
  input  logic [mtt_pkg::IDX_W-1:0]           cfg_index,
  input  logic [mtt_pkg::CFG_W-1:0]           cfg_data
);

  mtt_pkg::cfg_t     cfg;
  mtt_pkg::res_t     res;
  mtt_pkg::div_req_t div_req;
  mtt_pkg::div_rsp_t div_rsp;
  logic              out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reduction_ratio   <= mtt_pkg::RR_RESET;
      cfg.angle_tracking_on <= 1'b0;
      cfg.position_bias     <= mtt_pkg::PB_UNSET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mtt_pkg::REG_REDUCTION_RATIO:   cfg.reduction_ratio   <= cfg_data;
        mtt_pkg::REG_ANGLE_TRACKING_ON: cfg.angle_tracking_on <= cfg_data[0];
        mtt_pkg::REG_POSITION_BIAS:     cfg.position_bias     <= cfg_data[mtt_pkg::PB_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !out_valid || out_ready;

  // Hold the result until the transaction completes on the output side.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      rotor_position  <= res.rotor_position;
      rotor_speed     <= res.rotor_speed;
      current_amps    <= res.current_amps;
      torque_estimate <= res.torque_estimate;
      temperature     <= res.temperature;
      output_angle    <= res.output_angle;
      saturated       <= res.saturated;
    end
  end

  mtt_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .operation       (operation),
    .position_word   (position_word),
    .speed_word      (speed_word),
    .current_word    (current_word),
    .temperature_raw (temperature_raw),
    .bias_value      (bias_value),
    .cfg             (cfg),
    .out_free        (out_free),
    .res             (res),
    .div_req         (div_req),
    .div_rsp         (div_rsp)
  );

  mtt_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

endmodule

// ===== verif/motor_feedback_multiturn_tracker_core_test.sv =====
// ----------------------------------------------------------------------------
// motor_feedback_multiturn_tracker_core_test
// Self-checking bench for the motor feedback tracker. A scoreboard class
// predicts every result from the accepted input transactions: current and
// torque scaling, turn counting and the biased multi-turn angle. Each result
// is compared field by field with the oldest prediction. The stimulus covers
// edge values, threshold jumps, saturation, zero ratio and zero denominator,
// then random encoder walks with noise. These run under several register
// settings and sender/receiver idle patterns, including a long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module motor_feedback_multiturn_tracker_core_test;
  import mtt_pkg::*;

  localparam int     HOLD_CYCLES    = 1500;
  localparam int     SETTLE_CYCLES  = 300;
  localparam int     STUCK_LIMIT    = 20000;
  // speed and ratio that make the torque denominator exactly zero
  localparam int     ZERO_DEN_RATIO = 1327;
  localparam int     ZERO_DEN_SPEED = -99;
  localparam longint ANGLE_HI       = (longint'(1) << 47) - 1;
  localparam longint ANGLE_LO       = -(longint'(1) << 47);
  localparam longint TORQUE_HI      = longint'(2147483647);
  localparam longint TORQUE_LO      = -TORQUE_HI - 1;
  localparam longint DEG_PER_TURN   = 23592960;

  typedef struct packed {
    logic                    op;
    logic signed [POS_W-1:0] pos;
    logic signed [SPD_W-1:0] spd;
    logic signed [SPD_W-1:0] cur;
    logic [TEMP_W-1:0]       temp;
    logic signed [ANG_W-1:0] bias;
  } feedback_item_t;

  class tracker_scoreboard;
    logic [RR_W-1:0] ratio_reg;
    bit              tracking_on;
    logic [PB_W-1:0] bias_pos_reg;
    int              turn_count;
    longint          last_pos;
    bit              last_pos_valid;
    longint          angle_zero;
    bit              zero_known;
    longint          held_angle;
    res_t            expected_frames[$];
    int              mismatches;

    function new();
      ratio_reg      = RR_RESET;
      tracking_on    = 1'b0;
      bias_pos_reg   = PB_UNSET;
      turn_count     = 0;
      last_pos       = 0;
      last_pos_valid = 1'b0;
      angle_zero     = 0;
      zero_known     = 1'b0;
      held_angle     = 0;
      mismatches     = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_REDUCTION_RATIO:   ratio_reg = data[RR_W-1:0];
        REG_ANGLE_TRACKING_ON: tracking_on = data[0];
        REG_POSITION_BIAS:     bias_pos_reg = data[PB_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_frames.size();
    endfunction

    // Predict the result of one accepted transaction and update the turn state.
    function void take_item(feedback_item_t it);
      longint          pos, spd, cur, num, den, dq, nt, torque, rr, s, a, pb, diff;
      longint unsigned mag, qm, rm, m, rr_u;
      bit              sat, neg;
      res_t            r;
      if (it.op == OP_SET_BIAS) begin
        angle_zero     = it.bias;
        zero_known     = 1'b1;
        last_pos_valid = 1'b0;
        return;
      end
      sat = 1'b0;
      pos = it.pos;
      spd = it.spd;
      cur = it.cur;
      cur = cur * CUR_SCALE;
      rr  = ratio_reg;
      if (rr == 0) rr = 1;

      num = spd * PI_Q16 * 256;
      den = SPEED_DIV * rr;
      dq  = num / den + DQ_OFFSET;
      nt  = 24 * cur;
      if (nt <= 0) begin
        torque = 0;
      end else if (dq == 0) begin
        torque = TORQUE_HI;
        sat    = 1'b1;
      end else begin
        torque = (nt * 65536) / dq;
        if (torque > TORQUE_HI) begin
          torque = TORQUE_HI;
          sat    = 1'b1;
        end else if (torque < TORQUE_LO) begin
          torque = TORQUE_LO;
          sat    = 1'b1;
        end
      end

      if (tracking_on) begin
        if (last_pos_valid) begin
          diff = pos - last_pos;
          if (diff < -WRAP_THRESHOLD) turn_count++;
          else if (diff > WRAP_THRESHOLD) turn_count--;
        end
        s    = pos * DEG_PER_COUNT + longint'(turn_count) * DEG_PER_TURN;
        neg  = (s < 0);
        mag  = neg ? -s : s;
        rr_u = rr;
        qm   = mag / rr_u;
        rm   = mag % rr_u;
        if (qm >= (64'd1 << 40)) m = 64'd1 << 48;
        else m = qm * 256 + (rm * 256) / rr_u;
        if (neg) begin
          if (m > (64'd1 << 47)) begin
            a   = ANGLE_LO;
            sat = 1'b1;
          end else begin
            a = -longint'(m);
          end
        end else if (m > ANGLE_HI) begin
          a   = ANGLE_HI;
          sat = 1'b1;
        end else begin
          a = m;
        end
        // first angle fixes the zero unless a bias position is configured
        if (!zero_known) begin
          pb         = longint'(signed'(bias_pos_reg));
          angle_zero = (pb != -1) ? pb * DEG_PER_COUNT : a;
          zero_known = 1'b1;
        end
        diff = a - angle_zero;
        if (diff > ANGLE_HI) begin
          diff = ANGLE_HI;
          sat  = 1'b1;
        end else if (diff < ANGLE_LO) begin
          diff = ANGLE_LO;
          sat  = 1'b1;
        end
        held_angle     = diff;
        last_pos       = pos;
        last_pos_valid = 1'b1;
      end

      r.valid           = 1'b1;
      r.rotor_position  = it.pos;
      r.rotor_speed     = it.spd;
      r.current_amps    = cur[CUR_W-1:0];
      r.torque_estimate = torque[TQ_W-1:0];
      r.temperature     = it.temp;
      r.output_angle    = held_angle[ANG_W-1:0];
      r.saturated       = sat;
      expected_frames.push_back(r);
    endfunction

    function void flag(string what, logic [63:0] want, logic [63:0] seen);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, seen);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_frames.size() == 0) begin
        flag("unexpected transaction, rotor_position", '0, got.rotor_position);
        return;
      end
      want = expected_frames.pop_front();
      if (want.rotor_position !== got.rotor_position)
        flag("rotor_position", want.rotor_position, got.rotor_position);
      if (want.rotor_speed !== got.rotor_speed)
        flag("rotor_speed", want.rotor_speed, got.rotor_speed);
      if (want.current_amps !== got.current_amps)
        flag("current_amps", want.current_amps, got.current_amps);
      if (want.torque_estimate !== got.torque_estimate)
        flag("torque_estimate", want.torque_estimate, got.torque_estimate);
      if (want.temperature !== got.temperature)
        flag("temperature", want.temperature, got.temperature);
      if (want.output_angle !== got.output_angle)
        flag("output_angle", want.output_angle, got.output_angle);
      if (want.saturated !== got.saturated)
        flag("saturated", want.saturated, got.saturated);
    endfunction
  endclass

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    operation = OP_FEEDBACK;
  logic signed [POS_W-1:0] position_word = '0;
  logic signed [SPD_W-1:0] speed_word = '0;
  logic signed [SPD_W-1:0] current_word = '0;
  logic [TEMP_W-1:0]       temperature_raw = '0;
  logic signed [ANG_W-1:0] bias_value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [POS_W-1:0] rotor_position;
  logic signed [SPD_W-1:0] rotor_speed;
  logic signed [CUR_W-1:0] current_amps;
  logic signed [TQ_W-1:0]  torque_estimate;
  logic [TEMP_W-1:0]       temperature;
  logic signed [ANG_W-1:0] output_angle;
  logic                    saturated;
  logic                    cfg_we = 1'b0;
  logic [IDX_W-1:0]        cfg_index = '0;
  logic [CFG_W-1:0]        cfg_data = '0;

  tracker_scoreboard sb;
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int hold_seq       = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int walk_pos       = 0;
  int stuck_cycles   = 0;

  motor_feedback_multiturn_tracker_core uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .operation       (operation),
    .position_word   (position_word),
    .speed_word      (speed_word),
    .current_word    (current_word),
    .temperature_raw (temperature_raw),
    .bias_value      (bias_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .rotor_position  (rotor_position),
    .rotor_speed     (rotor_speed),
    .current_amps    (current_amps),
    .torque_estimate (torque_estimate),
    .temperature     (temperature),
    .output_angle    (output_angle),
    .saturated       (saturated),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(negedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    res_t got;
    if (!rst && out_valid && out_ready) begin
      got.valid           = 1'b1;
      got.rotor_position  = rotor_position;
      got.rotor_speed     = rotor_speed;
      got.current_amps    = current_amps;
      got.torque_estimate = torque_estimate;
      got.temperature     = temperature;
      got.output_angle    = output_angle;
      got.saturated       = saturated;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic feedback_item_t frame_item(int pos, int spd, int cur, int temp);
    feedback_item_t it;
    it.op   = OP_FEEDBACK;
    it.pos  = POS_W'(pos);
    it.spd  = SPD_W'(spd);
    it.cur  = SPD_W'(cur);
    it.temp = TEMP_W'(temp);
    it.bias = '0;
    return it;
  endfunction

  function automatic feedback_item_t bias_item(longint value);
    feedback_item_t it;
    it      = frame_item(0, 0, 0, 0);
    it.op   = OP_SET_BIAS;
    it.bias = ANG_W'(value);
    return it;
  endfunction

  // Mostly an encoder walk with wraps and threshold-sized jumps, some noise.
  function automatic feedback_item_t random_item();
    feedback_item_t it;
    int             roll, step;
    roll    = $urandom_range(0, 99);
    it.op   = OP_FEEDBACK;
    it.pos  = POS_W'(walk_pos);
    it.spd  = ($urandom_range(0, 9) < 6) ? SPD_W'(int'($urandom_range(0, 6000)) - 3000)
                                         : SPD_W'($urandom);
    it.cur  = SPD_W'($urandom);
    it.temp = TEMP_W'($urandom);
    it.bias = ANG_W'({$urandom, $urandom});
    if (roll < 4) begin
      it.op = OP_SET_BIAS;
      if ($urandom_range(0, 1))
        it.bias = ANG_W'(longint'(int'($urandom_range(0, 2000000)) - 1000000));
    end else if (roll < 14) begin
      it.pos = POS_W'($urandom);
    end else begin
      if (roll < 20) step = $urandom_range(0, 1) ? int'($urandom_range(4190, 4210))
                                                 : -int'($urandom_range(4190, 4210));
      else step = int'($urandom_range(0, 1400)) - 700;
      walk_pos = ((walk_pos + step) % 8192 + 8192) % 8192;
      it.pos   = POS_W'(walk_pos);
    end
    return it;
  endfunction

  task automatic push_item(input feedback_item_t it);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    operation       <= it.op;
    position_word   <= it.pos;
    speed_word      <= it.spd;
    current_word    <= it.cur;
    temperature_raw <= it.temp;
    bias_value      <= it.bias;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_item(it);
  endtask

  task automatic run_random(input int count);
    repeat (count) push_item(random_item());
  endtask

  // Drop valid, drain every expected transaction, then give in-flight work time.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic program_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  initial begin
    int pick;
    sb = new();
    // hold reset over a run of rising edges, release it on a falling edge
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Zero source for the first tracked angle: unset, other negative, or a position.
    pick = $urandom_range(0, 3);
    case (pick)
      0:       program_reg(REG_POSITION_BIAS, CFG_W'(-1));
      1:       program_reg(REG_POSITION_BIAS, CFG_W'(-2));
      2:       program_reg(REG_POSITION_BIAS, CFG_W'(0));
      default: program_reg(REG_POSITION_BIAS, CFG_W'(8191));
    endcase
    program_reg(REG_ANGLE_TRACKING_ON, CFG_W'(1));

    push_item(frame_item(0, 0, 0, 0));
    push_item(frame_item(8191, 32767, 32767, 255));
    push_item(frame_item(0, -32768, -32768, 0));
    push_item(frame_item(4200, 1, 1, 1));
    push_item(frame_item(0, -1, -1, 128));
    push_item(frame_item(4201, 100, 16384, 25));
    push_item(frame_item(0, -100, 8000, 60));
    push_item(frame_item(-32768, 3000, -16384, 90));
    push_item(frame_item(32767, -3000, 1, 200));
    push_item(bias_item(ANGLE_LO));
    push_item(frame_item(100, 500, 200, 30));
    push_item(bias_item(ANGLE_HI));
    push_item(frame_item(-32768, 500, 200, 31));
    push_item(bias_item(0));
    push_item(frame_item(500, 0, 4000, 32));
    settle();

    program_reg(REG_REDUCTION_RATIO, RR_RESET);
    run_random(300);
    settle();

    program_reg(REG_REDUCTION_RATIO, 16'hFFFF);
    send_gap_pct = 52;
    run_random(300);
    settle();

    program_reg(REG_REDUCTION_RATIO, CFG_W'(1));
    send_gap_pct   = 0;
    recv_stall_pct = 52;
    run_random(300);
    settle();

    // zero ratio counts as one
    program_reg(REG_REDUCTION_RATIO, CFG_W'(0));
    send_gap_pct   = 34;
    recv_stall_pct = 34;
    push_item(frame_item(8191, 32767, 32767, 7));
    run_random(250);
    settle();

    // tracking off: angle holds, turn state frozen
    program_reg(REG_ANGLE_TRACKING_ON, CFG_W'(0));
    program_reg(REG_REDUCTION_RATIO, CFG_W'($urandom_range(1, 65535)));
    program_reg(REG_POSITION_BIAS, CFG_W'($urandom_range(0, 8191)));
    run_random(250);
    settle();

    program_reg(REG_ANGLE_TRACKING_ON, CFG_W'(1));
    program_reg(REG_REDUCTION_RATIO, CFG_W'(ZERO_DEN_RATIO));
    send_gap_pct   = 52;
    recv_stall_pct = 0;
    push_item(frame_item(1000, ZERO_DEN_SPEED, 16384, 40));
    push_item(frame_item(1000, ZERO_DEN_SPEED, -5, 41));
    push_item(frame_item(1000, -ZERO_DEN_SPEED, 32767, 42));
    run_random(250);
    settle();

    // long output hold-off while input keeps coming
    program_reg(REG_REDUCTION_RATIO, CFG_W'($urandom_range(1, 4096)));
    send_gap_pct = 0;
    hold_seq++;
    run_random(200);
    settle();

    program_reg(REG_POSITION_BIAS, CFG_W'(-1));
    program_reg(REG_REDUCTION_RATIO, CFG_W'($urandom_range(1, 65535)));
    send_gap_pct   = 34;
    recv_stall_pct = 34;
    run_random(250);
    settle();

    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
